// File: hw/rtl/mixed_sign_divider_with_overflow_defines.svh
// Assertion macros shared by the divider RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MIXED_SIGN_DIVIDER_WITH_OVERFLOW_DEFINES_SVH
`define MIXED_SIGN_DIVIDER_WITH_OVERFLOW_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/msdiv_pkg.sv
// Package for the mixed-sign divider: field widths and default datapath width.
// No dependencies.
package msdiv_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned REM_W          = 31;
  localparam int unsigned IN_TDATA_W     = 64;
  localparam int unsigned OUT_TDATA_W    = 64;

endpackage

// File: hw/rtl/msdiv_cell.sv
// One restoring-division cell: produces one quotient bit per word and registers it.
// Depends on msdiv_pkg.
module msdiv_cell
  import msdiv_pkg::*;
#(
  parameter int unsigned DataWidth = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [DataWidth-2:0] rem_i,
  input  logic [DataWidth-1:0] nq_i,
  input  logic [DataWidth-1:0] mag_i,
  input  logic                 neg_i,
  input  logic [DataWidth-1:0] num_i,
  output logic                 valid_o,
  output logic [DataWidth-2:0] rem_o,
  output logic [DataWidth-1:0] nq_o,
  output logic [DataWidth-1:0] mag_o,
  output logic                 neg_o,
  output logic [DataWidth-1:0] num_o
);

  logic [DataWidth-1:0] trial;
  logic [DataWidth-1:0] diff;
  logic                 ge;
  logic                 valid_q;
  logic [DataWidth-2:0] rem_d, rem_q;
  logic [DataWidth-1:0] nq_d, nq_q;
  logic [DataWidth-1:0] mag_q;
  logic                 neg_q;
  logic [DataWidth-1:0] num_q;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_i, nq_i[DataWidth-1]};
    diff  = trial - mag_i;
    ge    = (trial >= mag_i);
    rem_d = ge ? diff[DataWidth-2:0] : trial[DataWidth-2:0];
    nq_d  = {nq_i[DataWidth-2:0], ge};
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q <= rem_d;
      nq_q  <= nq_d;
      mag_q <= mag_i;
      neg_q <= neg_i;
      num_q <= num_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;
  assign num_o   = num_q;

endmodule

// File: hw/rtl/msdiv_fin.sv
// Result stage: overflow check, sign fix-up and the output word register.
// Depends on msdiv_pkg.
module msdiv_fin
  import msdiv_pkg::*;
#(
  parameter int unsigned DataWidth = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [DataWidth-2:0] rem_i,
  input  logic [DataWidth-1:0] nq_i,
  input  logic [DataWidth-1:0] mag_i,
  input  logic                 neg_i,
  input  logic [DataWidth-1:0] num_i,
  input  logic                 ready_i,
  output logic                 valid_o,
  output logic [FIELD_W-1:0]   quotient_o,
  output logic [REM_W-1:0]     remainder_o,
  output logic                 error_flag_o
);

  logic                 err;
  logic [DataWidth-1:0] qs;
  logic                 load;
  logic                 valid_d, valid_q;
  logic [FIELD_W-1:0]   quot_d, quot_q;
  logic [REM_W-1:0]     rem_d, rem_q;
  logic                 err_q;

  // zero divisor, or overflow: positive quotient needs msb clear, negative allows exactly 2^(W-1)
  always_comb begin
    err = (mag_i == '0) ||
          (neg_i ? (nq_i[DataWidth-1] && (|nq_i[DataWidth-2:0])) : nq_i[DataWidth-1]);
    qs  = neg_i ? (~nq_i + 1'b1) : nq_i;
    if (err) begin
      quot_d = FIELD_W'(num_i);
      rem_d  = '0;
    end else begin
      quot_d = FIELD_W'($signed(qs));
      rem_d  = REM_W'(rem_i);
    end
  end

  // load when a word arrives and the register is free or draining
  assign load = adv_i && valid_i;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      err_q  <= err;
    end
  end

  assign valid_o      = valid_q;
  assign quotient_o   = quot_q;
  assign remainder_o  = rem_q;
  assign error_flag_o = err_q;

endmodule

// File: hw/rtl/mixed_sign_divider_with_overflow.sv
// Top level of the mixed-sign divider: input stage, chain of division cells,
// result stage. Depends on msdiv_pkg, msdiv_cell, msdiv_fin and the defines header.
//
// Usage:
//   Input word on s_axis: dividend (unsigned) and divisor (two's complement).
//   Output word on m_axis: quotient, remainder and error flag in tuser.
//   Quotient truncates toward zero; remainder is non-negative. On a zero
//   divisor or a quotient that does not fit in signed DataWidth bits the error
//   flag is set, the quotient carries the dividend and the remainder is 0.
//   Path: the input register loads at the accept edge, then one cell per
//   quotient bit, then one result register.
//   Throughput: one word per cycle while the chain is not stalled; the input
//   register and the cell chain hold up to DataWidth + 1 words in flight,
//   the result register one more.
//   Stall: when the result register holds an untaken word and the last cell
//   is full, the whole chain holds and s_axis_tready drops; otherwise the
//   chain keeps moving and closes up bubbles at its end.
//   Reset: all stage valids and the output valid clear; in-flight words
//   are dropped.
`include "mixed_sign_divider_with_overflow_defines.svh"

module mixed_sign_divider_with_overflow
  import msdiv_pkg::*;
#(
  parameter int unsigned DataWidth = DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] dividend, [63:32] divisor
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] quotient, [62:32] remainder, [63] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] error_flag
  output logic                   m_axis_tuser
);

  localparam int unsigned NStg = DataWidth + 1;

  logic                 adv;
  logic [DataWidth-1:0] den;
  logic                 v_s   [NStg];
  logic [DataWidth-2:0] rem_s [NStg];
  logic [DataWidth-1:0] nq_s  [NStg];
  logic [DataWidth-1:0] mag_s [NStg];
  logic                 neg_s [NStg];
  logic [DataWidth-1:0] num_s [NStg];
  logic                 in_v_q;
  logic [DataWidth-1:0] in_num_q;
  logic [DataWidth-1:0] in_mag_q;
  logic                 in_neg_q;
  logic [FIELD_W-1:0]   quotient;
  logic [REM_W-1:0]     remainder;
  logic                 error_flag;

  // chain moves unless the result register is stuck and the last cell is full
  assign adv           = !m_axis_tvalid || m_axis_tready || !v_s[NStg-1];
  assign s_axis_tready = adv;

  // input stage: take divisor magnitude
  assign den = s_axis_tdata[FIELD_W +: DataWidth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_num_q <= s_axis_tdata[DataWidth-1:0];
      in_neg_q <= den[DataWidth-1];
      in_mag_q <= den[DataWidth-1] ? (~den + 1'b1) : den;
    end
  end

  assign v_s[0]   = in_v_q;
  assign rem_s[0] = '0;
  assign nq_s[0]  = in_num_q;
  assign mag_s[0] = in_mag_q;
  assign neg_s[0] = in_neg_q;
  assign num_s[0] = in_num_q;

  // one cell per quotient bit, msb first
  for (genvar g = 0; g < DataWidth; g++) begin : g_cell
    msdiv_cell #(
      .DataWidth(DataWidth)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(v_s[g]),
      .rem_i  (rem_s[g]),
      .nq_i   (nq_s[g]),
      .mag_i  (mag_s[g]),
      .neg_i  (neg_s[g]),
      .num_i  (num_s[g]),
      .valid_o(v_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .nq_o   (nq_s[g+1]),
      .mag_o  (mag_s[g+1]),
      .neg_o  (neg_s[g+1]),
      .num_o  (num_s[g+1])
    );
  end

  msdiv_fin #(
    .DataWidth(DataWidth)
  ) u_fin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (v_s[NStg-1]),
    .rem_i       (rem_s[NStg-1]),
    .nq_i        (nq_s[NStg-1]),
    .mag_i       (mag_s[NStg-1]),
    .neg_i       (neg_s[NStg-1]),
    .num_i       (num_s[NStg-1]),
    .ready_i     (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .quotient_o  (quotient),
    .remainder_o (remainder),
    .error_flag_o(error_flag)
  );

  assign m_axis_tdata = {1'b0, remainder, quotient};
  assign m_axis_tuser = error_flag;

  // assertions
  `MSD_ASSERT_NOW(a_stall_cause, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready && v_s[NStg-1], "input stalled without output backpressure")
  `MSD_ASSERT_NOW(a_err_rem_zero, m_axis_tvalid && m_axis_tuser,
    remainder == '0, "error word with nonzero remainder")
  `MSD_ASSERT_NOW(a_rem_below_mag, v_s[NStg-1] && (mag_s[NStg-1] != '0),
    DataWidth'(rem_s[NStg-1]) < mag_s[NStg-1], "final remainder not below divisor magnitude")
  `MSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

// File: dv/tb_mixed_sign_divider_with_overflow.sv
// Testbench for mixed_sign_divider_with_overflow: stream driver, stream monitor and
// a self-contained division predictor that checks every result word in order.
// Depends on msdiv_pkg and the divider RTL.
module tb_mixed_sign_divider_with_overflow;
  import msdiv_pkg::*;

  localparam int unsigned DataWidth   = DATA_WIDTH_DEF;
  localparam int unsigned NumRandom   = 1600;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = DataWidth + 8;

  typedef struct {
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
  } div_word_t;

  typedef struct {
    logic [FIELD_W-1:0] quotient;
    logic [REM_W-1:0]   remainder;
    logic               error_flag;
  } div_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  div_word_t   pending_words[$];
  div_result_t expected_results[$];
  int          total_words;
  int          words_sent = 0;
  int          error_cnt = 0;
  int          idle_cycles = 0;
  int          hold_left = 0;
  bit          pressure_done = 1'b0;
  bit          in_taken = 1'b0;
  int          tx_idle_pct;
  int          rx_idle_pct;

  mixed_sign_divider_with_overflow dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Unsigned dividend over two's-complement divisor, truncating toward zero
  function automatic div_result_t predict_division(logic [FIELD_W-1:0] dividend,
                                                   logic [FIELD_W-1:0] divisor);
    div_result_t res;
    logic        neg;
    logic [32:0] mag;
    logic [32:0] qmag;
    logic [32:0] rmag;
    logic        ovf;
    neg = divisor[31];
    // 33 bits so the most negative divisor keeps its exact magnitude
    mag = neg ? (33'd0 - {1'b1, divisor}) : {1'b0, divisor};
    if (mag == 33'd0) begin
      ovf  = 1'b1;
      qmag = '0;
      rmag = '0;
    end else begin
      qmag = {1'b0, dividend} / mag;
      rmag = {1'b0, dividend} % mag;
      ovf  = neg ? (qmag > 33'h0_8000_0000) : (qmag > 33'h0_7FFF_FFFF);
    end
    if (ovf) begin
      res.quotient   = dividend;
      res.remainder  = '0;
      res.error_flag = 1'b1;
    end else begin
      res.quotient   = neg ? (32'd0 - qmag[31:0]) : qmag[31:0];
      res.remainder  = rmag[REM_W-1:0];
      res.error_flag = 1'b0;
    end
    return res;
  endfunction

  // Clock and the single reset pulse
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle rates per phase: sender light / receiver heavy, swapped, then none
  always_comb begin
    if (words_sent < total_words / 3) begin
      tx_idle_pct = 7;
      rx_idle_pct = 66;
    end else if (words_sent < (2 * total_words) / 3) begin
      tx_idle_pct = 66;
      rx_idle_pct = 7;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // Driver: offers the next pending word, holds it until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_words[0].divisor, pending_words[0].dividend};
          void'(pending_words.pop_front());
          words_sent <= words_sent + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure plus one long hold-off in the no-idle phase
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (!pressure_done && words_sent >= (2 * total_words) / 3 + 50) begin
        m_axis_tready <= 1'b0;
        hold_left     <= HoldCycles;
        pressure_done <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Monitor: predict on input accept, compare on output accept
  always @(posedge clk_i) begin
    div_result_t exp_res;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_division(s_axis_tdata[31:0],
                                                    s_axis_tdata[63:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          error_cnt = error_cnt + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.quotient) begin
            $error("quotient: expected %h, actual %h", exp_res.quotient,
                   m_axis_tdata[31:0]);
            error_cnt = error_cnt + 1;
          end
          if (m_axis_tdata[62:32] !== exp_res.remainder) begin
            $error("remainder: expected %h, actual %h", exp_res.remainder,
                   m_axis_tdata[62:32]);
            error_cnt = error_cnt + 1;
          end
          if (m_axis_tuser !== exp_res.error_flag) begin
            $error("error_flag: expected %b, actual %b", exp_res.error_flag,
                   m_axis_tuser);
            error_cnt = error_cnt + 1;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    div_word_t w;
    int        kind;
    int        dkind;
    logic [31:0] mag;

    // Directed: zero and unit divisors, overflow edges, most negative divisor
    pending_words.push_back('{32'h0000_0000, 32'h0000_0000});
    pending_words.push_back('{32'hFFFF_FFFF, 32'h0000_0000});
    pending_words.push_back('{32'hFFFF_FFFF, 32'h0000_0001});
    pending_words.push_back('{32'h7FFF_FFFF, 32'h0000_0001});
    pending_words.push_back('{32'h8000_0000, 32'h0000_0001});
    pending_words.push_back('{32'h8000_0000, 32'hFFFF_FFFF});
    pending_words.push_back('{32'h8000_0001, 32'hFFFF_FFFF});
    pending_words.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_words.push_back('{32'hFFFF_FFFF, 32'h0000_0002});
    pending_words.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFE});
    pending_words.push_back('{32'h0000_0000, 32'h8000_0000});
    pending_words.push_back('{32'hFFFF_FFFF, 32'h8000_0000});
    pending_words.push_back('{32'h8000_0000, 32'h8000_0000});
    pending_words.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_words.push_back('{32'hFFFF_FFFF, 32'h7FFF_FFFF});
    pending_words.push_back('{32'h0000_0005, 32'h0000_0003});
    pending_words.push_back('{32'h0000_0005, 32'hFFFF_FFFD});
    pending_words.push_back('{32'h0000_0000, 32'hFFFF_FFFF});
    pending_words.push_back('{32'h0000_0064, 32'hFFFF_FFF9});
    pending_words.push_back('{32'h0000_0003, 32'h0000_0007});

    // Random: divisor classes chosen to hit errors, boundaries and plain cases
    for (int i = 0; i < NumRandom; i++) begin
      kind  = $urandom_range(9);
      dkind = $urandom_range(3);
      case (dkind)
        0: w.dividend = $urandom_range(255);
        1: w.dividend = 32'h8000_0000 + $urandom_range(8) - 4;
        default: w.dividend = $urandom;
      endcase
      case (kind)
        0: w.divisor = 32'h0000_0000;
        1: w.divisor = $urandom_range(1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
        2: w.divisor = 32'h8000_0000 + $urandom_range(2);
        3: begin
          mag       = $urandom_range(255, 1);
          w.divisor = $urandom_range(1) ? (32'd0 - mag) : mag;
        end
        4: begin
          mag       = 32'd1 << $urandom_range(31);
          w.divisor = $urandom_range(1) ? (32'd0 - mag) : mag;
        end
        5: begin
          // Quotient right around the signed limit
          mag        = $urandom_range(2, 1);
          w.dividend = (mag == 1) ? (32'h8000_0000 + $urandom_range(2) - 1)
                                  : (32'hFFFF_FFFF - $urandom_range(3));
          w.divisor  = $urandom_range(1) ? (32'd0 - mag) : mag;
        end
        default: w.divisor = $urandom;
      endcase
      pending_words.push_back(w);
    end
    total_words = pending_words.size();

    // Wait for every word to be taken, then for every result
    wait (rst_ni);
    do @(posedge clk_i); while (pending_words.size() > 0 || s_axis_tvalid);
    do @(posedge clk_i); while (expected_results.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
